// ===== rtl/core/windowed_fft_spectrum_macros.svh =====
// assertion macros for the windowed fft spectrum block
`ifndef WINDOWED_FFT_SPECTRUM_MACROS_SVH
`define WINDOWED_FFT_SPECTRUM_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define WFS_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define WFS_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/wfs_pkg.sv =====
// shared types, constants and table functions of the windowed fft spectrum block
`default_nettype none
package wfs_pkg;

   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint HAM_A_Q30   = 64'sd579820585;
   localparam longint HAM_B_Q30   = 64'sd493921239;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_MUL,
      ST_LOAD_WR,
      ST_READ_OUT,
      ST_REV_RDA,
      ST_REV_RDB,
      ST_REV_WRA,
      ST_REV_WRB,
      ST_BF_RDA,
      ST_BF_RDB,
      ST_BF_MUL,
      ST_BF_SUM,
      ST_BF_WRA,
      ST_BF_WRB
   } state_type;

   typedef enum logic [2:0] {
      WSEL_LOAD,
      WSEL_SWAP_J,
      WSEL_SWAP_I,
      WSEL_BF_SUM,
      WSEL_BF_DIFF
   } wsel_type;

   typedef struct packed {
      logic     we;
      wsel_type wsel;
      logic     cap_sample;
      logic     cap_a;
      logic     prod_en;
      logic     mul_en;
      logic     sum_en;
   } cmd_type;

   typedef struct packed {
      longint c;
      longint s;
   } trig_type;

   // q30 cos and sin over one eighth of a turn, r in 0..8192 of 16384
   function automatic trig_type eighth_cs(input longint r);
      trig_type res;
      longint x, x2, ts, tc, ss, cs;
      x  = (r * HALF_PI_Q30) / 16384;
      x2 = (x * x) >>> 30;
      ts = x;
      tc = ONE_Q30;
      ss = x;
      cs = ONE_Q30;
      ts = ((ts * x2) >>> 30) / 6;   tc = ((tc * x2) >>> 30) / 2;
      ss = ss - ts;                  cs = cs - tc;
      ts = ((ts * x2) >>> 30) / 20;  tc = ((tc * x2) >>> 30) / 12;
      ss = ss + ts;                  cs = cs + tc;
      ts = ((ts * x2) >>> 30) / 42;  tc = ((tc * x2) >>> 30) / 30;
      ss = ss - ts;                  cs = cs - tc;
      ts = ((ts * x2) >>> 30) / 72;  tc = ((tc * x2) >>> 30) / 56;
      ss = ss + ts;                  cs = cs + tc;
      ts = ((ts * x2) >>> 30) / 110; tc = ((tc * x2) >>> 30) / 90;
      ss = ss - ts;                  cs = cs - tc;
      res.c = cs;
      res.s = ss;
      return res;
   endfunction

   // signed q30 cos and sin of a phase in 1/65536 turns
   function automatic trig_type phase_cs(input longint p);
      trig_type b, res;
      longint q, r;
      q = (p >>> 14) & 3;
      r = p & 16383;
      if (r <= 8192) begin
         b = eighth_cs(r);
      end else begin
         res = eighth_cs(16384 - r);
         b.c = res.s;
         b.s = res.c;
      end
      case (q)
         0: begin res.c = b.c;  res.s = b.s;  end
         1: begin res.c = -b.s; res.s = b.c;  end
         2: begin res.c = -b.c; res.s = -b.s; end
         default: begin res.c = b.s; res.s = -b.c; end
      endcase
      return res;
   endfunction

   function automatic longint sat_q15(input longint v);
      longint res;
      res = v;
      if (v > 32767) res = 32767;
      if (v < -32768) res = -32768;
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wfs_ctrl.sv =====
// controller: sequencing of loads, reads, bit-reverse pass and butterflies
`default_nettype none
`include "windowed_fft_spectrum_macros.svh"
module wfs_ctrl #(
   parameter int POINTS = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic                                 req_mode,
   input  wire logic [9:0]                           req_bin_index,
   output logic                                      busy,
   output logic                                      rsp_strobe,
   output logic                                      frame_valid,
   output wfs_pkg::cmd_type                          cmd,
   output logic [((POINTS >= (1 << $clog2(POINTS))) ? $clog2(POINTS)
                  : $clog2(POINTS) - 1) - 1:0]       rd_addr,
   output logic [((POINTS >= (1 << $clog2(POINTS))) ? $clog2(POINTS)
                  : $clog2(POINTS) - 1) - 1:0]       wr_addr,
   output logic [((POINTS >= (1 << $clog2(POINTS))) ? $clog2(POINTS)
                  : $clog2(POINTS) - 1) - 1:0]       win_addr,
   output logic [(((POINTS >= (1 << $clog2(POINTS))) ? $clog2(POINTS)
                  : $clog2(POINTS) - 1) > 1 ?
                  ((POINTS >= (1 << $clog2(POINTS))) ? $clog2(POINTS)
                  : $clog2(POINTS) - 1) - 1 : 1) - 1:0] tw_addr
);
   import wfs_pkg::*;

   localparam int LOG = (POINTS >= (1 << $clog2(POINTS))) ? $clog2(POINTS)
                        : $clog2(POINTS) - 1;
   localparam int TWW = (LOG > 1) ? LOG - 1 : 1;
   localparam int SW  = (LOG > 1) ? $clog2(LOG) : 1;
   localparam logic [LOG-1:0] LAST_IDX   = LOG'((1 << LOG) - 1);
   localparam logic [LOG-1:0] LAST_M     = LOG'((1 << (LOG - 1)) - 1);
   localparam logic [SW-1:0]  LAST_STAGE = SW'(LOG - 1);

   state_type      state_ff, state_in;
   logic [LOG-1:0] load_cnt_ff, load_cnt_in;
   logic [LOG-1:0] idx_ff, idx_in;
   logic [SW-1:0]  stage_ff, stage_in;
   logic           flag_ff, flag_in;

   logic [LOG-1:0] rev_idx;
   logic [LOG-1:0] half_mask;
   logic [LOG-1:0] low_m;
   logic [LOG-1:0] addr_a;
   logic [LOG-1:0] addr_b;
   logic [SW-1:0]  tw_shift;
   logic [LOG-1:0] tw_full;

   always_comb begin
      for (int b = 0; b < LOG; b++) begin
         rev_idx[LOG-1-b] = idx_ff[b];
      end
   end

   // butterfly m of stage s: a is m with a zero bit put in at position s
   assign half_mask = (LOG'(1) << stage_ff) - LOG'(1);
   assign low_m     = idx_ff & half_mask;
   assign addr_a    = ((idx_ff & ~half_mask) << 1) | low_m;
   assign addr_b    = addr_a | (LOG'(1) << stage_ff);
   assign tw_shift  = LAST_STAGE - stage_ff;
   assign tw_full   = low_m << tw_shift;
   assign tw_addr   = tw_full[TWW-1:0];
   assign win_addr  = load_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         load_cnt_ff <= '0;
         idx_ff      <= '0;
         stage_ff    <= '0;
         flag_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         idx_ff      <= idx_in;
         stage_ff    <= stage_in;
         flag_ff     <= flag_in;
      end
   end

   // next state and loop counters
   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      idx_in      = idx_ff;
      stage_in    = stage_ff;
      flag_in     = flag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = req_mode ? ST_READ_OUT : ST_LOAD_MUL;
            end
         end
         ST_LOAD_MUL: state_in = ST_LOAD_WR;
         ST_LOAD_WR: begin
            if (load_cnt_ff == LAST_IDX) begin
               load_cnt_in = '0;
               idx_in      = '0;
               state_in    = ST_REV_RDA;
            end else begin
               load_cnt_in = load_cnt_ff + LOG'(1);
               state_in    = ST_IDLE;
            end
         end
         ST_READ_OUT: state_in = ST_IDLE;
         ST_REV_RDA, ST_REV_WRB: begin
            if (state_ff == ST_REV_RDA && rev_idx > idx_ff) begin
               state_in = ST_REV_RDB;
            end else if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               stage_in = '0;
               state_in = ST_BF_RDA;
            end else begin
               idx_in   = idx_ff + LOG'(1);
               state_in = ST_REV_RDA;
            end
         end
         ST_REV_RDB: state_in = ST_REV_WRA;
         ST_REV_WRA: state_in = ST_REV_WRB;
         ST_BF_RDA:  state_in = ST_BF_RDB;
         ST_BF_RDB:  state_in = ST_BF_MUL;
         ST_BF_MUL:  state_in = ST_BF_SUM;
         ST_BF_SUM:  state_in = ST_BF_WRA;
         ST_BF_WRA:  state_in = ST_BF_WRB;
         ST_BF_WRB: begin
            if (idx_ff == LAST_M) begin
               idx_in = '0;
               if (stage_ff == LAST_STAGE) begin
                  flag_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  stage_in = stage_ff + SW'(1);
                  state_in = ST_BF_RDA;
               end
            end else begin
               idx_in   = idx_ff + LOG'(1);
               state_in = ST_BF_RDA;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd            = '0;
      cmd.wsel       = WSEL_LOAD;
      rd_addr        = idx_ff;
      wr_addr        = load_cnt_ff;
      busy           = 1'b1;
      rsp_strobe     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy           = 1'b0;
            rd_addr        = LOG'(req_bin_index);
            cmd.cap_sample = start & ~req_mode;
         end
         ST_LOAD_MUL: cmd.prod_en = 1'b1;
         ST_LOAD_WR:  cmd.we = 1'b1;
         ST_READ_OUT: rsp_strobe = 1'b1;
         ST_REV_RDA:  rd_addr = idx_ff;
         ST_REV_RDB: begin
            rd_addr   = rev_idx;
            cmd.cap_a = 1'b1;
         end
         ST_REV_WRA: begin
            cmd.we   = 1'b1;
            cmd.wsel = WSEL_SWAP_J;
            wr_addr  = idx_ff;
         end
         ST_REV_WRB: begin
            cmd.we   = 1'b1;
            cmd.wsel = WSEL_SWAP_I;
            wr_addr  = rev_idx;
         end
         ST_BF_RDA: rd_addr = addr_a;
         ST_BF_RDB: begin
            rd_addr   = addr_b;
            cmd.cap_a = 1'b1;
         end
         ST_BF_MUL: cmd.mul_en = 1'b1;
         ST_BF_SUM: cmd.sum_en = 1'b1;
         ST_BF_WRA: begin
            cmd.we   = 1'b1;
            cmd.wsel = WSEL_BF_SUM;
            wr_addr  = addr_a;
         end
         ST_BF_WRB: begin
            cmd.we   = 1'b1;
            cmd.wsel = WSEL_BF_DIFF;
            wr_addr  = addr_b;
         end
         default: busy = 1'b1;
      endcase
   end

   assign frame_valid = flag_ff;

   `WFS_ASSERT_NXT(a_read_gives_word, start && !busy && req_mode, rsp_strobe,
      "read request not answered in the next cycle")
   `WFS_ASSERT_NXT(a_load_is_silent, start && !busy && !req_mode, busy && !rsp_strobe,
      "load request produced a response word")
   `WFS_ASSERT_NXT(a_flag_sticky, frame_valid, frame_valid,
      "frame valid flag dropped outside reset")
   `WFS_ASSERT_IMP(a_no_write_on_resp, rsp_strobe, !cmd.we,
      "memory written while a response word is shown")

endmodule
`default_nettype wire

// ===== rtl/core/wfs_dpath.sv =====
// datapath: work memory, window and twiddle roms, windowing and butterfly arithmetic
`default_nettype none
module wfs_dpath #(
   parameter int POINTS = 1024
) (
   input  wire logic                                 clock,
   input  wire wfs_pkg::cmd_type                     cmd,
   input  wire logic [((POINTS >= (1 << $clog2(POINTS))) ? $clog2(POINTS)
                  : $clog2(POINTS) - 1) - 1:0]       rd_addr,
   input  wire logic [((POINTS >= (1 << $clog2(POINTS))) ? $clog2(POINTS)
                  : $clog2(POINTS) - 1) - 1:0]       wr_addr,
   input  wire logic [((POINTS >= (1 << $clog2(POINTS))) ? $clog2(POINTS)
                  : $clog2(POINTS) - 1) - 1:0]       win_addr,
   input  wire logic [(((POINTS >= (1 << $clog2(POINTS))) ? $clog2(POINTS)
                  : $clog2(POINTS) - 1) > 1 ?
                  ((POINTS >= (1 << $clog2(POINTS))) ? $clog2(POINTS)
                  : $clog2(POINTS) - 1) - 1 : 1) - 1:0] tw_addr,
   input  wire logic                                 frame_valid,
   input  wire logic signed [15:0]                   req_sample,
   output logic signed [31:0]                        rsp_bin_real,
   output logic signed [31:0]                        rsp_bin_imag
);
   import wfs_pkg::*;

   localparam int LOG  = (POINTS >= (1 << $clog2(POINTS))) ? $clog2(POINTS)
                         : $clog2(POINTS) - 1;
   localparam int N    = 1 << LOG;
   localparam int NTW  = (N / 2 > 0) ? N / 2 : 1;

   typedef logic [15:0] win_rom_type [N];
   typedef logic [31:0] tw_rom_type [NTW];

   function automatic win_rom_type build_win();
      win_rom_type rom;
      trig_type t;
      longint h;
      for (int i = 0; i < N; i++) begin
         t = phase_cs(longint'(i) << (16 - LOG));
         h = HAM_A_Q30 - ((HAM_B_Q30 * t.c + (64'sd1 <<< 29)) >>> 30);
         h = (h + 64'sd16384) >>> 15;
         if (h < 0) h = 0;
         h = sat_q15(h);
         rom[i] = 16'(h);
      end
      return rom;
   endfunction

   function automatic tw_rom_type build_tw();
      tw_rom_type rom;
      trig_type t;
      longint re, im;
      for (int i = 0; i < NTW; i++) begin
         t  = phase_cs(longint'(i) << (16 - LOG));
         re = sat_q15((t.c + 64'sd16384) >>> 15);
         im = sat_q15((t.s + 64'sd16384) >>> 15);
         rom[i] = {16'(im), 16'(re)};
      end
      return rom;
   endfunction

   localparam win_rom_type WIN_ROM = build_win();
   localparam tw_rom_type  TW_ROM  = build_tw();

   logic [63:0]        mem [N];
   logic [63:0]        rd_ff;
   logic [63:0]        a_ff;
   logic [15:0]        win_ff;
   logic [31:0]        tw_ff;
   logic signed [15:0] sample_ff;
   logic signed [31:0] prod_ff;
   logic signed [47:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [31:0] tr_ff, ti_ff;

   logic signed [31:0] br, bi, ar, ai;
   logic signed [15:0] wr, ws;
   logic signed [48:0] sum_re, sum_im;
   logic signed [31:0] prod_in;
   logic signed [31:0] prod_neg;
   logic signed [31:0] win_val;
   logic [63:0]        wr_data;

   assign br = rd_ff[31:0];
   assign bi = rd_ff[63:32];
   assign ar = a_ff[31:0];
   assign ai = a_ff[63:32];
   assign wr = tw_ff[15:0];
   assign ws = tw_ff[31:16];

   // truncate toward zero
   assign prod_in  = sample_ff * $signed({1'b0, win_ff});
   assign prod_neg = -prod_ff;
   assign win_val  = prod_ff[31] ? -(prod_neg >>> 15) : (prod_ff >>> 15);

   // rounded once after the two products are summed
   assign sum_re = 49'(p0_ff) + 49'(p1_ff) + 49'sd16384;
   assign sum_im = 49'(p2_ff) - 49'(p3_ff) + 49'sd16384;

   always_comb begin
      case (cmd.wsel)
         WSEL_LOAD:    wr_data = {32'd0, win_val};
         WSEL_SWAP_J:  wr_data = rd_ff;
         WSEL_SWAP_I:  wr_data = a_ff;
         WSEL_BF_SUM:  wr_data = {ai + ti_ff, ar + tr_ff};
         WSEL_BF_DIFF: wr_data = {ai - ti_ff, ar - tr_ff};
         default:      wr_data = rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff  <= mem[rd_addr];
      win_ff <= WIN_ROM[win_addr];
      tw_ff  <= TW_ROM[tw_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_sample) begin
         sample_ff <= req_sample;
      end
      if (cmd.prod_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.cap_a) begin
         a_ff <= rd_ff;
      end
      if (cmd.mul_en) begin
         p0_ff <= br * wr;
         p1_ff <= bi * ws;
         p2_ff <= bi * wr;
         p3_ff <= br * ws;
      end
      if (cmd.sum_en) begin
         tr_ff <= 32'(sum_re >>> 15);
         ti_ff <= 32'(sum_im >>> 15);
      end
   end

   assign rsp_bin_real = frame_valid ? rd_ff[31:0]  : 32'sd0;
   assign rsp_bin_imag = frame_valid ? rd_ff[63:32] : 32'sd0;

endmodule
`default_nettype wire

// ===== rtl/core/windowed_fft_spectrum.sv =====
// top level of the windowed fft spectrum block: controller plus datapath
//
//   channel    ports                                          handshake
//   request    req_mode, req_sample, req_bin_index            start & !busy
//   response   rsp_bin_real, rsp_bin_imag, rsp_frame_valid    rsp_strobe, one cycle
//
// a load word is windowed and written; the last load of a frame then runs the transform
// a read word shows its response word in the cycle after accept
// transform: a bit-reverse pass that swaps each pair once, then (N/2)*log2(N)
// butterflies on one unit, each read, multiplied, summed and written back
// reset clears the controller, load count and frame flag; the memory needs none
// the response side cannot stall, so a response word is never held
`default_nettype none
module windowed_fft_spectrum #(
   parameter int POINTS = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_mode,
   input  wire logic signed [15:0] req_sample,
   input  wire logic [9:0]         req_bin_index,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_bin_real,
   output logic signed [31:0]      rsp_bin_imag,
   output logic                    rsp_frame_valid
);
   import wfs_pkg::*;

   // frame length is the largest power of two not above POINTS
   localparam int LOG = (POINTS >= (1 << $clog2(POINTS))) ? $clog2(POINTS)
                        : $clog2(POINTS) - 1;
   localparam int TWW = (LOG > 1) ? LOG - 1 : 1;

   cmd_type        cmd;
   logic [LOG-1:0] rd_addr;
   logic [LOG-1:0] wr_addr;
   logic [LOG-1:0] win_addr;
   logic [TWW-1:0] tw_addr;
   logic           frame_valid;

   // sequencing: loads, reads, bit-reverse swaps, butterfly steps
   wfs_ctrl #(
      .POINTS(POINTS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_mode      (req_mode),
      .req_bin_index (req_bin_index),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe),
      .frame_valid   (frame_valid),
      .cmd           (cmd),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_addr),
      .win_addr      (win_addr),
      .tw_addr       (tw_addr)
   );

   // memory, roms and arithmetic
   wfs_dpath #(
      .POINTS(POINTS)
   ) u_dpath (
      .clock        (clock),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr),
      .win_addr     (win_addr),
      .tw_addr      (tw_addr),
      .frame_valid  (frame_valid),
      .req_sample   (req_sample),
      .rsp_bin_real (rsp_bin_real),
      .rsp_bin_imag (rsp_bin_imag)
   );

   // reads before the first frame give zero parts and a clear flag
   assign rsp_frame_valid = frame_valid;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the windowed fft spectrum block
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // frame length: largest power of two not above the block's size
   localparam int NPTS = 1024;
   localparam int NLOG = 10;
   // q30 constants of the trig series and the hamming coefficients
   localparam longint Q30_HALF_PI = 64'sd1686629713;
   localparam longint Q30_ONE     = 64'sd1073741824;
   localparam longint Q30_HAM_A   = 64'sd579820585;
   localparam longint Q30_HAM_B   = 64'sd493921239;
   localparam int WATCHDOG_LIMIT  = 200000;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef struct {
      int   re;
      int   im;
      logic valid;
   } bin_word_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_mode;
   logic signed [15:0] req_sample;
   logic [9:0]         req_bin_index;
   logic               rsp_strobe;
   logic signed [31:0] rsp_bin_real;
   logic signed [31:0] rsp_bin_imag;
   logic               rsp_frame_valid;

   windowed_fft_spectrum #(.POINTS(NPTS)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_sample      (req_sample),
      .req_bin_index   (req_bin_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_bin_real    (rsp_bin_real),
      .rsp_bin_imag    (rsp_bin_imag),
      .rsp_frame_valid (rsp_frame_valid)
   );

   // predictor state: spectrum store, load position, frame flag
   int           spec_re [NPTS];
   int           spec_im [NPTS];
   int           hamming_q15 [NPTS];
   int           twid_cos [NPTS/2];
   int           twid_sin [NPTS/2];
   int           load_pos;
   logic         have_frame;
   bin_word_type pending_bins [$];

   int words_sent;
   int loads_sent;
   int reads_sent;
   int bins_checked;
   int errors;
   int idle_cycles;
   int sender_idle_pct;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // floor of v / 2^s after adding half an lsb
   function automatic longint round_shr(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic int clamp_q15(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   // taylor series for cos and sin over one eighth turn, q30, r of 16384
   task automatic series_cs(input longint r, output longint c, output longint s);
      longint x, x2, term_s, term_c;
      x      = (r * Q30_HALF_PI) / 16384;
      x2     = (x * x) >>> 30;
      term_s = x;
      term_c = Q30_ONE;
      s      = x;
      c      = Q30_ONE;
      for (int k = 1; k <= 5; k++) begin
         term_s = ((term_s * x2) >>> 30) / ((2*k) * (2*k + 1));
         term_c = ((term_c * x2) >>> 30) / ((2*k - 1) * (2*k));
         if (k % 2 == 1) begin
            s -= term_s;
            c -= term_c;
         end else begin
            s += term_s;
            c += term_c;
         end
      end
   endtask

   // full-turn cos and sin, phase in 1/65536 turns, unfolded by symmetry
   task automatic turn_cs(input longint ph, output longint c, output longint s);
      longint quad, rem, bc, bs;
      quad = (ph >> 14) & 3;
      rem  = ph & 16383;
      if (rem <= 8192) series_cs(rem, bc, bs);
      else series_cs(16384 - rem, bs, bc);
      case (quad)
         0: begin c = bc;  s = bs;  end
         1: begin c = -bs; s = bc;  end
         2: begin c = -bc; s = -bs; end
         default: begin c = bs; s = -bc; end
      endcase
   endtask

   task automatic build_tables();
      longint c, s, h;
      for (int i = 0; i < NPTS; i++) begin
         turn_cs(longint'(i) << (16 - NLOG), c, s);
         h = round_shr(Q30_HAM_A - round_shr(Q30_HAM_B * c, 30), 15);
         if (h < 0) h = 0;
         hamming_q15[i] = clamp_q15(h);
         if (i < NPTS/2) begin
            twid_cos[i] = clamp_q15(round_shr(c, 15));
            twid_sin[i] = clamp_q15(round_shr(s, 15));
         end
      end
   endtask

   // in-place radix-2 dit transform over the predicted store
   task automatic transform_frame();
      int j, t, lo, hi, half, stride;
      longint ar, ai, br, bi, wr, ws, tr, ti;
      for (int i = 0; i < NPTS; i++) begin
         j = 0;
         for (int b = 0; b < NLOG; b++)
            if (i[b]) j |= 1 << (NLOG - 1 - b);
         if (j > i) begin
            t = spec_re[i]; spec_re[i] = spec_re[j]; spec_re[j] = t;
            t = spec_im[i]; spec_im[i] = spec_im[j]; spec_im[j] = t;
         end
      end
      for (int span = 2; span <= NPTS; span <<= 1) begin
         half   = span / 2;
         stride = NPTS / span;
         for (int base = 0; base < NPTS; base += span) begin
            for (int k = 0; k < half; k++) begin
               lo = base + k;
               hi = lo + half;
               ar = spec_re[lo]; ai = spec_im[lo];
               br = spec_re[hi]; bi = spec_im[hi];
               wr = twid_cos[k * stride];
               ws = twid_sin[k * stride];
               tr = round_shr(br * wr + bi * ws, 15);
               ti = round_shr(bi * wr - br * ws, 15);
               // sums wrap to 32 bits
               spec_re[lo] = int'(ar + tr);
               spec_im[lo] = int'(ai + ti);
               spec_re[hi] = int'(ar - tr);
               spec_im[hi] = int'(ai - ti);
            end
         end
      end
   endtask

   // predictor: apply one accepted word, queue the expected bin for a read
   task automatic predict_word(input logic mode, input logic signed [15:0] smp,
                               input logic [9:0] idx);
      longint prod;
      bin_word_type bw;
      if (mode == MODE_LOAD) begin
         prod = longint'(smp) * hamming_q15[load_pos];
         // truncate toward zero
         spec_re[load_pos] = (prod >= 0) ? int'(prod >>> 15) : -int'((-prod) >>> 15);
         spec_im[load_pos] = 0;
         load_pos++;
         if (load_pos >= NPTS) begin
            transform_frame();
            have_frame = 1'b1;
            load_pos   = 0;
         end
      end else begin
         bw.re    = have_frame ? spec_re[idx % NPTS] : 0;
         bw.im    = have_frame ? spec_im[idx % NPTS] : 0;
         bw.valid = have_frame;
         pending_bins = {pending_bins, bw};
      end
   endtask

   // send one word, with a random gap ahead of it in the idling phases
   task automatic send_word(input logic mode, input logic signed [15:0] smp,
                            input logic [9:0] idx);
      int gap;
      gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start         = 1'b1;
      req_mode      = mode;
      req_sample    = smp;
      req_bin_index = idx;
      do @(posedge clock); while (busy);
      predict_word(mode, smp, idx);
      words_sent++;
      if (mode == MODE_LOAD) loads_sent++;
      else reads_sent++;
      // idling profile switches as the run progresses
      if (words_sent == 450) sender_idle_pct = 45;
      if (words_sent == 900) sender_idle_pct = 0;
   endtask

   task automatic load_sample(input logic signed [15:0] smp);
      send_word(MODE_LOAD, smp, 10'($urandom));
   endtask

   task automatic read_bin(input logic [9:0] idx);
      send_word(MODE_READ, 16'($urandom), idx);
   endtask

   task automatic drain_bins();
      wait (pending_bins.size() == 0);
   endtask

   // reads before any frame return zero with frame_valid low
   task automatic test_reads_before_frame();
      read_bin(10'd0);
      read_bin(10'd1023);
      read_bin(10'd512);
      read_bin(10'($urandom));
   endtask

   // first full frame: extreme samples up front, then random, reads mixed in
   task automatic test_first_frame();
      logic signed [15:0] extremes [6];
      extremes = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1, 16'sh8000};
      foreach (extremes[i]) load_sample(extremes[i]);
      while (loads_sent < NPTS) begin
         if ($urandom_range(9) == 0) read_bin(10'($urandom));
         else if ($urandom_range(15) == 0) load_sample($urandom_range(1) ? 16'sh7fff : 16'sh8000);
         else load_sample(16'($urandom));
      end
   endtask

   // spectrum reads after the transform, edge bins and random bins
   task automatic test_spectrum_reads();
      read_bin(10'd0);
      read_bin(10'd1);
      read_bin(10'd511);
      read_bin(10'd512);
      read_bin(10'd1023);
      repeat (45) read_bin(10'($urandom));
   endtask

   // hold off until every read is back before the next phase
   task automatic test_pause_until_idle();
      @(negedge clock);
      start = 1'b0;
      drain_bins();
   endtask

   // second frame partly loaded: low entries are new windowed samples
   task automatic test_partial_reload();
      repeat (110) begin
         if ($urandom_range(3) == 0) begin
            // aim at the boundary between new and old entries now and then
            if ($urandom_range(1)) read_bin(10'(load_pos + $urandom_range(3) - 2));
            else read_bin(10'($urandom));
         end else begin
            load_sample(16'($urandom));
         end
      end
   endtask

   // response checker: each strobe is compared with the oldest expected bin
   always @(posedge clock) begin
      bin_word_type want;
      if (!reset && rsp_strobe) begin
         if (pending_bins.size() == 0) begin
            $error("unexpected response word: real %0d imag %0d", rsp_bin_real, rsp_bin_imag);
            errors++;
         end else begin
            want = pending_bins.pop_front();
            bins_checked++;
            if (rsp_bin_real !== want.re) begin
               $error("bin_real expected %0d actual %0d", want.re, rsp_bin_real);
               errors++;
            end
            if (rsp_bin_imag !== want.im) begin
               $error("bin_imag expected %0d actual %0d", want.im, rsp_bin_imag);
               errors++;
            end
            if (rsp_frame_valid !== want.valid) begin
               $error("frame_valid expected %0b actual %0b", want.valid, rsp_frame_valid);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles with no accepted word and no response
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int settle;
      reset           = 1'b1;
      start           = 1'b0;
      req_mode        = MODE_LOAD;
      req_sample      = '0;
      req_bin_index   = '0;
      load_pos        = 0;
      have_frame      = 1'b0;
      words_sent      = 0;
      loads_sent      = 0;
      reads_sent      = 0;
      bins_checked    = 0;
      errors          = 0;
      idle_cycles     = 0;
      sender_idle_pct = 13;
      build_tables();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reads_before_frame();
      test_first_frame();
      test_spectrum_reads();
      test_pause_until_idle();
      test_partial_reload();
      test_spectrum_reads();

      @(negedge clock);
      start = 1'b0;
      // wait for outstanding reads, then watch for stray strobes
      settle = 0;
      while (pending_bins.size() != 0 && settle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         settle++;
      end
      repeat (10) @(posedge clock);

      $display("covered %0d words: %0d sample loads, %0d bin reads, %0d bins checked",
               words_sent, loads_sent, reads_sent, bins_checked);
      $display("one full frame transformed, reads before, during and after a reload");
      if (errors == 0 && pending_bins.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire
